@@ rtl/core/uemf_pkg.sv @@
package uemf_pkg;

    localparam int SEL_W  = 3;
    localparam int TIME_W = 20;
    localparam int CM_W   = 15;
    localparam int HIST_N = 3;

    localparam int NUM_SENSORS_DEF = 5;
    localparam int QUEUE_DEPTH_DEF = 4;

    // t / 58 == floor(floor(t / 29) / 2); estimate by reciprocal, fix by one compare
    localparam int CM_DIVISOR = 58;
    localparam int DIV_MUL    = 1157049;   // floor(2^26 / 58)
    localparam int DIV_SHIFT  = 26;
    localparam int DIV_PROD_W = 41;

    // sum / 3, exact for sum < 2^17
    localparam int SUM_W       = 17;
    localparam int MEAN_MUL    = 87382;    // ceil(2^18 / 3)
    localparam int MEAN_SHIFT  = 18;
    localparam int MEAN_PROD_W = 35;

    localparam logic FILTER_MEDIAN  = 1'b0;
    localparam logic FILTER_NEAREST = 1'b1;

    typedef struct packed {
        logic            in_range;
        logic [SEL_W-1:0] sel;
        logic [CM_W-1:0]  raw;
    } t_item;

endpackage

@@ rtl/core/ultrasonic_echo_median_filter_unit.sv @@
// Per-sensor echo distance filter. Each input beat carries a sensor index and an
// echo pulse width in microseconds; each output beat carries the raw distance
// floor(t/58) cm and a filtered distance from that sensor's last three readings
// (median in mode 0, the reading nearest the truncated mean in mode 1, newer
// reading wins a tie). Histories reset to zero and those zeros count as readings.
// A sensor index at or above NUM_SENSORS leaves all histories alone and returns
// the raw value as the filtered one. Sustained rate is one beat per clock while
// the output accepts; an accepted beat passes six register stages on its way out
// (two conversion stages, the queue, history update, median/mean stage and the
// selection stage, the output register). The front converter and the back filter
// are split by a small queue so either side may stall. Write i_cfg_we only while
// no beats are in flight.
module ultrasonic_echo_median_filter_unit #(
    parameter int NUM_SENSORS = uemf_pkg::NUM_SENSORS_DEF,
    parameter int QUEUE_DEPTH = uemf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: filter_mode
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [2:0] sensor_index, [22:3] echo_time_us, [23] zero
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [14:0] filtered_cm, [29:15] raw_cm, [31:30] zero
);
    import uemf_pkg::*;

    logic r_mode;

    // front -> queue
    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    // queue -> back
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    logic [CM_W-1:0] filt_cm;
    logic [CM_W-1:0] raw_cm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= FILTER_MEDIAN;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // converts time to cm and flags whether the sensor has a history
    uemf_front #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_sel   (i_s_axis_tdata[SEL_W-1:0]),
        .i_time  (i_s_axis_tdata[SEL_W + TIME_W - 1:SEL_W]),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    uemf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_item  (f_item),
        .o_rd_valid (q_valid),
        .i_rd_en    (q_pop),
        .o_rd_item  (q_item)
    );

    // history update and filtering, output register at its end
    uemf_back #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_valid    (q_valid),
        .o_pop      (q_pop),
        .i_item     (q_item),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_filtered (filt_cm),
        .o_raw      (raw_cm)
    );

    assign o_m_axis_tdata = {2'b00, raw_cm, filt_cm};

endmodule

@@ rtl/core/uemf_front.sv @@
module uemf_front #(
    parameter int NUM_SENSORS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [uemf_pkg::SEL_W-1:0]     i_sel,
    input  logic [uemf_pkg::TIME_W-1:0]    i_time,
    output logic                           o_valid,
    input  logic                           i_ready,
    output uemf_pkg::t_item                o_item
);
    import uemf_pkg::*;

    // stage A: reciprocal estimate
    logic                  r_a_valid;
    logic [SEL_W-1:0]      r_a_sel;
    logic [TIME_W-1:0]     r_a_time;
    logic [CM_W-1:0]       r_a_q0;
    // stage B: corrected quotient, classified
    logic                  r_b_valid;
    t_item                 r_b_item;

    logic                  a_ready;
    logic                  b_ready;
    logic [DIV_PROD_W-1:0] prod;
    logic [TIME_W:0]       rem;
    logic [CM_W-1:0]       q_fix;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    assign prod  = DIV_PROD_W'(i_time) * DIV_PROD_W'(DIV_MUL);
    assign rem   = {1'b0, r_a_time} - ((TIME_W + 1)'(r_a_q0) * (TIME_W + 1)'(CM_DIVISOR));
    assign q_fix = r_a_q0 + CM_W'(rem >= (TIME_W + 1)'(CM_DIVISOR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_sel  <= i_sel;
            r_a_time <= i_time;
            r_a_q0   <= prod[DIV_SHIFT + CM_W - 1:DIV_SHIFT];
        end
        if (b_ready && r_a_valid) begin
            r_b_item.in_range <= (32'(r_a_sel) < 32'(NUM_SENSORS));
            r_b_item.sel      <= r_a_sel;
            r_b_item.raw      <= q_fix;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

@@ rtl/core/uemf_queue.sv @@
module uemf_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  uemf_pkg::t_item i_wr_item,
    output logic            o_rd_valid,
    input  logic            i_rd_en,
    output uemf_pkg::t_item o_rd_item
);
    import uemf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_en && o_rd_valid;
    assign o_rd_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

@@ rtl/core/uemf_back.sv @@
module uemf_back #(
    parameter int NUM_SENSORS = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_mode,
    input  logic                       i_valid,
    output logic                       o_pop,
    input  uemf_pkg::t_item            i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [uemf_pkg::CM_W-1:0]  o_filtered,
    output logic [uemf_pkg::CM_W-1:0]  o_raw
);
    import uemf_pkg::*;

    localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    logic [CM_W-1:0] r_hist [NUM_SENSORS][HIST_N];

    // stage C: history update
    logic            r_c_valid;
    logic            r_c_in;
    logic [CM_W-1:0] r_c_raw;
    logic [CM_W-1:0] r_c_h [HIST_N];
    // stage D: median and mean
    logic            r_d_valid;
    logic            r_d_in;
    logic [CM_W-1:0] r_d_raw;
    logic [CM_W-1:0] r_d_h [HIST_N];
    logic [CM_W-1:0] r_d_med;
    logic [CM_W-1:0] r_d_mean;
    // stage E: output register
    logic            r_e_valid;
    logic [CM_W-1:0] r_e_filt;
    logic [CM_W-1:0] r_e_raw;

    logic             c_ready;
    logic             d_ready;
    logic             e_ready;
    logic             pop;
    logic [IDX_W-1:0] idx;

    logic [SUM_W-1:0]       sum;
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [CM_W-1:0]        mn_ab;
    logic [CM_W-1:0]        mx_ab;
    logic [CM_W-1:0]        mn_mx_c;
    logic [CM_W-1:0]        med;

    logic [CM_W-1:0] diff [HIST_N];
    logic [CM_W-1:0] pick1;
    logic [CM_W-1:0] dpick1;
    logic [CM_W-1:0] pick;
    logic [CM_W-1:0] filt;

    assign e_ready = !r_e_valid || i_ready;
    assign d_ready = !r_d_valid || e_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign pop     = i_valid && c_ready;
    assign o_pop   = pop;
    assign idx     = IDX_W'(i_item.sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SENSORS; s++) begin
                for (int k = 0; k < HIST_N; k++) begin
                    r_hist[s][k] <= '0;
                end
            end
        end else if (pop && i_item.in_range) begin
            r_hist[idx][0] <= i_item.raw;
            r_hist[idx][1] <= r_hist[idx][0];
            r_hist[idx][2] <= r_hist[idx][1];
        end
    end

    // stage D math
    assign sum       = SUM_W'(r_c_h[0]) + SUM_W'(r_c_h[1]) + SUM_W'(r_c_h[2]);
    assign mean_prod = MEAN_PROD_W'(sum) * MEAN_PROD_W'(MEAN_MUL);
    assign mn_ab     = (r_c_h[0] < r_c_h[1]) ? r_c_h[0] : r_c_h[1];
    assign mx_ab     = (r_c_h[0] > r_c_h[1]) ? r_c_h[0] : r_c_h[1];
    assign mn_mx_c   = (mx_ab < r_c_h[2]) ? mx_ab : r_c_h[2];
    assign med       = (mn_ab > mn_mx_c) ? mn_ab : mn_mx_c;

    // stage E math: nearest to mean, strict compare so newer entry wins ties
    always_comb begin
        for (int k = 0; k < HIST_N; k++) begin
            diff[k] = (r_d_h[k] > r_d_mean) ? r_d_h[k] - r_d_mean : r_d_mean - r_d_h[k];
        end
        if (diff[0] > diff[1]) begin
            pick1  = r_d_h[1];
            dpick1 = diff[1];
        end else begin
            pick1  = r_d_h[0];
            dpick1 = diff[0];
        end
        pick = (dpick1 > diff[2]) ? r_d_h[2] : pick1;
        if (!r_d_in) begin
            filt = r_d_raw;
        end else if (i_mode == FILTER_NEAREST) begin
            filt = pick;
        end else begin
            filt = r_d_med;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (c_ready) begin
                r_c_valid <= i_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
            if (e_ready) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_c_in  <= i_item.in_range;
            r_c_raw <= i_item.raw;
            r_c_h[0] <= i_item.raw;
            r_c_h[1] <= r_hist[idx][0];
            r_c_h[2] <= r_hist[idx][1];
        end
        if (d_ready && r_c_valid) begin
            r_d_in   <= r_c_in;
            r_d_raw  <= r_c_raw;
            r_d_h    <= r_c_h;
            r_d_med  <= med;
            r_d_mean <= mean_prod[MEAN_SHIFT + CM_W - 1:MEAN_SHIFT];
        end
        if (e_ready && r_d_valid) begin
            r_e_filt <= filt;
            r_e_raw  <= r_d_raw;
        end
    end

    assign o_valid    = r_e_valid;
    assign o_filtered = r_e_filt;
    assign o_raw      = r_e_raw;

endmodule
